// ===== rtl/vfv_pkg.sv =====
package vfv_pkg;

	// Chunk geometry: CHUNK_WIDTH along x and z, CHUNK_HEIGHT along y.
	localparam int CHUNK_WIDTH  = 16;
	localparam int CHUNK_HEIGHT = 128;
	localparam int STORE_DEPTH  = CHUNK_WIDTH * CHUNK_WIDTH * CHUNK_HEIGHT;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);

	localparam int POS_X_W = 4;
	localparam int POS_Y_W = 7;
	localparam int POS_Z_W = 4;
	localparam int TYPE_W  = 8;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Input tdata, last field in the lowest bits.
	typedef struct packed {
		logic                pad;
		logic [TYPE_W-1:0]   block_type;
		logic [POS_Z_W-1:0]  pos_z;
		logic [POS_Y_W-1:0]  pos_y;
		logic [POS_X_W-1:0]  pos_x;
	} in_item_t;

	// Output tdata, last field in the lowest bits.
	typedef struct packed {
		logic [1:0]          pad;
		logic                hidden_z_plus;
		logic                hidden_z_minus;
		logic                hidden_y_plus;
		logic                hidden_y_minus;
		logic                hidden_x_plus;
		logic                hidden_x_minus;
		logic [TYPE_W-1:0]   material;
		logic                solid;
		logic [POS_Z_W-1:0]  out_z;
		logic [POS_Y_W-1:0]  out_y;
		logic [POS_X_W-1:0]  out_x;
	} out_item_t;

	typedef enum logic [2:0] {
		DIR_CENTER,
		DIR_XM,
		DIR_XP,
		DIR_YM,
		DIR_YP,
		DIR_ZM,
		DIR_ZP
	} dir_t;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] addr;
	} nb_t;

	// Request to the block store: one write port, two read ports.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [TYPE_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr_a;
		logic [ADDR_W-1:0] rd_addr_b;
	} mem_req_t;

	// Cell at a unit offset from (x, y, z): whether it lies in the chunk, and its address.
	function automatic nb_t neighbor(input logic [POS_X_W-1:0] x,
	                                 input logic [POS_Y_W-1:0] y,
	                                 input logic [POS_Z_W-1:0] z,
	                                 input dir_t d);
		nb_t r;
		int  nx;
		int  ny;
		int  nz;
		nx = int'(x);
		ny = int'(y);
		nz = int'(z);
		unique case (d)
			DIR_XM: nx = nx - 1;
			DIR_XP: nx = nx + 1;
			DIR_YM: ny = ny - 1;
			DIR_YP: ny = ny + 1;
			DIR_ZM: nz = nz - 1;
			DIR_ZP: nz = nz + 1;
			default: ;
		endcase
		r.ok = (nx >= 0) && (nx < CHUNK_WIDTH) && (ny >= 0) && (ny < CHUNK_HEIGHT) &&
		       (nz >= 0) && (nz < CHUNK_WIDTH);
		r.addr = r.ok ? ADDR_W'((ny * CHUNK_WIDTH + nz) * CHUNK_WIDTH + nx) : '0;
		return r;
	endfunction

endpackage

// ===== rtl/voxel_face_visibility_unit.sv =====
// Channel   Dir  Signals                               Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser     one write or query request
// m_        out  m_tvalid m_tready m_tdata             one result per query
// cfg_      in   cfg_valid cfg_ready cfg_data          culling_enable register
//
// A query's block and six neighbors are seven reads on two read ports, issued in pairs
// from the request through ST_RD3; the result loads in ST_FIN once the output is free,
// when the next request can already enter, so a query holds the input through ST_RD3.
// After reset the store is cleared to air, one entry a cycle, over all STORE_DEPTH (32768)
// entries; s_tready stays low during that pass, while cfg writes are taken.
// A query stalls in the cycle where its result loads while the previous one waits.
module voxel_face_visibility_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pos_x[3:0], pos_y[10:4], pos_z[14:11], block_type[22:15]
	input  logic [0:0]  s_tuser,   // kind[0]: 0 write, 1 query
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_x[3:0], out_y[10:4], out_z[14:11], solid[15],
	                               // material[23:16], hidden_x_minus[24], hidden_x_plus[25],
	                               // hidden_y_minus[26], hidden_y_plus[27],
	                               // hidden_z_minus[28], hidden_z_plus[29]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // culling_enable
);

	// The query sequencer. ST_RD1 to ST_RD3 issue the later read pairs while the
	// previous pair comes back; ST_FIN takes the last read and loads the result.
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD1   = 6'b000100,
		ST_RD2   = 6'b001000,
		ST_RD3   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	logic [vfv_pkg::ADDR_W-1:0]      clr_q;
	logic                            cull_q;

	logic [vfv_pkg::POS_X_W-1:0]     px_q;
	logic [vfv_pkg::POS_Y_W-1:0]     py_q;
	logic [vfv_pkg::POS_Z_W-1:0]     pz_q;
	logic                            ok_a_s1;
	logic                            ok_b_s1;
	logic [vfv_pkg::TYPE_W-1:0]      mat_q;
	logic                            hid_xm_q;
	logic                            hid_xp_q;
	logic                            hid_ym_q;
	logic                            hid_yp_q;
	logic                            hid_zm_q;

	logic                            m_tvalid_q;
	vfv_pkg::out_item_t              m_tdata_q;

	vfv_pkg::in_item_t               in_item;
	logic                            is_query;
	logic                            accept;
	logic                            out_free;
	logic                            issue_state;
	logic                            load_out;

	logic [vfv_pkg::POS_X_W-1:0]     cx;
	logic [vfv_pkg::POS_Y_W-1:0]     cy;
	logic [vfv_pkg::POS_Z_W-1:0]     cz;
	vfv_pkg::dir_t                   dir_a;
	vfv_pkg::dir_t                   dir_b;
	vfv_pkg::nb_t                    nb_a;
	vfv_pkg::nb_t                    nb_b;
	vfv_pkg::nb_t                    wr_nb;
	vfv_pkg::mem_req_t               mem_req;
	logic [vfv_pkg::TYPE_W-1:0]      rd_a_q;
	logic [vfv_pkg::TYPE_W-1:0]      rd_b_q;
	logic                            hid_a;
	logic                            hid_b;
	logic                            face_on;
	vfv_pkg::out_item_t              result;

	assign in_item  = vfv_pkg::in_item_t'(s_tdata);
	assign is_query = (s_tuser[0] == vfv_pkg::KIND_QUERY);
	assign out_free = !m_tvalid_q || m_tready;

	// New requests enter in idle, or in the last query cycle once the result can leave.
	assign s_tready  = (state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free);
	assign accept    = s_tvalid && s_tready;
	assign load_out  = (state_q == ST_FIN) && out_free;
	assign cfg_ready = 1'b1;

	// Coordinates of the first read pair come straight from the request; later pairs
	// use the held coordinates.
	assign issue_state = (state_q == ST_IDLE) || (state_q == ST_FIN);
	assign cx = issue_state ? in_item.pos_x : px_q;
	assign cy = issue_state ? in_item.pos_y : py_q;
	assign cz = issue_state ? in_item.pos_z : pz_q;

	always_comb begin
		unique case (state_q)
			ST_RD1: begin
				dir_a = vfv_pkg::DIR_XP;
				dir_b = vfv_pkg::DIR_YM;
			end
			ST_RD2: begin
				dir_a = vfv_pkg::DIR_YP;
				dir_b = vfv_pkg::DIR_ZM;
			end
			ST_RD3: begin
				dir_a = vfv_pkg::DIR_ZP;
				dir_b = vfv_pkg::DIR_ZP;
			end
			default: begin
				dir_a = vfv_pkg::DIR_CENTER;
				dir_b = vfv_pkg::DIR_XM;
			end
		endcase
	end

	assign nb_a  = vfv_pkg::neighbor(cx, cy, cz, dir_a);
	assign nb_b  = vfv_pkg::neighbor(cx, cy, cz, dir_b);
	assign wr_nb = vfv_pkg::neighbor(in_item.pos_x, in_item.pos_y, in_item.pos_z,
	                                 vfv_pkg::DIR_CENTER);

	// Outside the clearing pass, writes happen only in idle or in the last query cycle,
	// after all reads of the running query, so reads and writes of one entry never overlap.
	always_comb begin
		mem_req.rd_addr_a = nb_a.addr;
		mem_req.rd_addr_b = nb_b.addr;
		if (state_q == ST_CLEAR) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = clr_q;
			mem_req.wr_data = '0;
			mem_req.rd_en   = 1'b0;
		end else begin
			mem_req.wr_en   = accept && !is_query && wr_nb.ok;
			mem_req.wr_addr = wr_nb.addr;
			mem_req.wr_data = in_item.block_type;
			mem_req.rd_en   = (accept && is_query) || (state_q == ST_RD1) ||
			                  (state_q == ST_RD2) || (state_q == ST_RD3);
		end
	end

	vfv_store u_store (
		.clk    (clk),
		.req    (mem_req),
		.rd_a_q (rd_a_q),
		.rd_b_q (rd_b_q)
	);

	// A neighbor hides the face when it lies outside the chunk or is solid.
	assign hid_a = !ok_a_s1 || (rd_a_q != '0);
	assign hid_b = !ok_b_s1 || (rd_b_q != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ST_CLEAR: begin
				if (clr_q == vfv_pkg::ADDR_W'(vfv_pkg::STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE, ST_FIN: begin
				if (accept && is_query) begin
					state_d = ST_RD1;
				end else if (state_q == ST_IDLE || out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD1: state_d = ST_RD2;
			ST_RD2: state_d = ST_RD3;
			ST_RD3: state_d = ST_FIN;
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cull_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + vfv_pkg::ADDR_W'(1);
			end
			if (cfg_valid) begin
				cull_q <= cfg_data;
			end
		end
	end

	// Per-query datapath: coordinates, in-chunk flags of the pair in flight, and the
	// gathered block type and face flags.
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			px_q <= in_item.pos_x;
			py_q <= in_item.pos_y;
			pz_q <= in_item.pos_z;
		end
		if (mem_req.rd_en) begin
			ok_a_s1 <= nb_a.ok;
			ok_b_s1 <= nb_b.ok;
		end
		unique case (state_q)
			ST_RD1: begin
				// A block outside the chunk reads as air.
				mat_q    <= ok_a_s1 ? rd_a_q : '0;
				hid_xm_q <= hid_b;
			end
			ST_RD2: begin
				hid_xp_q <= hid_a;
				hid_ym_q <= hid_b;
			end
			ST_RD3: begin
				hid_yp_q <= hid_a;
				hid_zm_q <= hid_b;
			end
			default: ;
		endcase
	end

	// Air draws no faces, and with culling off every flag is clear.
	assign face_on = (mat_q != '0) && cull_q;

	always_comb begin
		result                = '0;
		result.out_x          = px_q;
		result.out_y          = py_q;
		result.out_z          = pz_q;
		result.solid          = (mat_q != '0);
		result.material       = mat_q;
		result.hidden_x_minus = face_on && hid_xm_q;
		result.hidden_x_plus  = face_on && hid_xp_q;
		result.hidden_y_minus = face_on && hid_ym_q;
		result.hidden_y_plus  = face_on && hid_yp_q;
		result.hidden_z_minus = face_on && hid_zm_q;
		result.hidden_z_plus  = face_on && hid_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/vfv_store.sv =====
// Block type store: one write port and two read ports, read data registered.
module vfv_store (
	input  logic                            clk,
	input  vfv_pkg::mem_req_t               req,
	output logic [vfv_pkg::TYPE_W-1:0]      rd_a_q,
	output logic [vfv_pkg::TYPE_W-1:0]      rd_b_q
);

	logic [vfv_pkg::TYPE_W-1:0] mem [vfv_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_a_q <= mem[req.rd_addr_a];
			rd_b_q <= mem[req.rd_addr_b];
		end
	end

endmodule

// ===== rtl/vfv_checker.sv =====
// Port-level checks on the voxel face visibility unit.
module vfv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic query_acc;

	assign query_acc = s_tvalid && s_tready && (s_tuser[0] == vfv_pkg::KIND_QUERY);

	// A result that is not taken stays as it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A query occupies the store read ports after it is taken, and s_tready stays low meanwhile.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("request taken during a running query");

	// An output that comes up from empty belongs to an earlier accepted query.
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(query_acc, 5))
		else $error("result without a matching query");

endmodule

bind voxel_face_visibility_unit vfv_checker u_vfv_checker (.*);
